@@ src/hrp_pkg.sv @@
// Shared types, codes and byte classification for the HTTP/1 request byte parser.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package hrp_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned ROLE_W   = 4;
    localparam int unsigned IDX_W    = 8;
    localparam int unsigned STATUS_W = 2;

    localparam logic [BYTE_W-1:0] MAX_HEADERS_RST = 8'd64;

    // Role codes carried on each result item.
    localparam logic [ROLE_W-1:0] ROLE_METHOD    = 4'd0;
    localparam logic [ROLE_W-1:0] ROLE_SP1       = 4'd1;
    localparam logic [ROLE_W-1:0] ROLE_URI       = 4'd2;
    localparam logic [ROLE_W-1:0] ROLE_SP2       = 4'd3;
    localparam logic [ROLE_W-1:0] ROLE_VERSION   = 4'd4;
    localparam logic [ROLE_W-1:0] ROLE_RL_EOL    = 4'd5;
    localparam logic [ROLE_W-1:0] ROLE_KEY       = 4'd6;
    localparam logic [ROLE_W-1:0] ROLE_KEY_SP    = 4'd7;
    localparam logic [ROLE_W-1:0] ROLE_COLON     = 4'd8;
    localparam logic [ROLE_W-1:0] ROLE_VAL_SP    = 4'd9;
    localparam logic [ROLE_W-1:0] ROLE_VALUE     = 4'd10;
    localparam logic [ROLE_W-1:0] ROLE_HDR_EOL   = 4'd11;
    localparam logic [ROLE_W-1:0] ROLE_FINAL_EOL = 4'd12;
    localparam logic [ROLE_W-1:0] ROLE_REJECTED  = 4'd13;
    localparam logic [ROLE_W-1:0] ROLE_AFTER_END = 4'd14;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_BUSY    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MANY    = 2'd3;

    // Byte literals the grammar looks for.
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0d;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0a;
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3a;
    localparam logic [BYTE_W-1:0] CH_H     = 8'h48;
    localparam logic [BYTE_W-1:0] CH_T     = 8'h54;
    localparam logic [BYTE_W-1:0] CH_P     = 8'h50;
    localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2f;
    localparam logic [BYTE_W-1:0] CH_ONE   = 8'h31;
    localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2e;
    localparam logic [BYTE_W-1:0] CH_DEL   = 8'h7f;
    localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;

    // Classification of one byte, computed once in the front part.
    typedef struct packed {
        logic tok;
        logic uri;
        logic digit;
        logic sp;
        logic cr;
        logic lf;
        logic colon;
        logic ch_h;
        logic ch_t;
        logic ch_p;
        logic ch_slash;
        logic ch_one;
        logic ch_dot;
    } t_cls;

    // One queued item: restart flag plus the byte's classes.
    typedef struct packed {
        logic first;
        t_cls cls;
    } t_q_item;

    function automatic logic tok_byte(input logic [BYTE_W-1:0] c);
        logic r;
        if (c <= CH_SP || c >= CH_DEL) begin
            r = 1'b0;
        end else begin
            unique case (c)
                8'h22, 8'h28, 8'h29, 8'h2c, 8'h2f,
                8'h3a, 8'h3b, 8'h3c, 8'h3d, 8'h3e, 8'h3f,
                8'h40, 8'h5b, 8'h5c, 8'h5d, 8'h7b, 8'h7d: r = 1'b0;
                default: r = 1'b1;
            endcase
        end
        return r;
    endfunction

    function automatic t_cls classify(input logic [BYTE_W-1:0] c);
        t_cls k;
        k.tok      = tok_byte(c);
        k.uri      = (c > CH_SP) && (c != CH_DEL);
        k.digit    = (c >= 8'h30) && (c <= 8'h39);
        k.sp       = (c == CH_SP);
        k.cr       = (c == CH_CR);
        k.lf       = (c == CH_LF);
        k.colon    = (c == CH_COLON);
        k.ch_h     = (c == CH_H);
        k.ch_t     = (c == CH_T);
        k.ch_p     = (c == CH_P);
        k.ch_slash = (c == CH_SLASH);
        k.ch_one   = (c == CH_ONE);
        k.ch_dot   = (c == CH_DOT);
        return k;
    endfunction

endpackage

`default_nettype wire

@@ src/hrp_if.sv @@
// Valid/ready channel interfaces for request bytes in and parse results out.
// Depends on hrp_pkg for field widths.
`default_nettype none

interface hrp_in_if import hrp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              first;

    modport source (output valid, output data_byte, output first, input ready);
    modport sink   (input valid, input data_byte, input first, output ready);
endinterface

interface hrp_out_if import hrp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ROLE_W-1:0]   role;
    logic [IDX_W-1:0]    header_index;
    logic                cr_was_data;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output role, output header_index,
                    output cr_was_data, output status, input ready);
    modport sink   (input valid, input role, input header_index,
                    input cr_was_data, input status, output ready);
endinterface

`default_nettype wire

@@ src/hrp_front.sv @@
// Front part: accepts request bytes and classifies them for the queue.
// Depends on hrp_pkg and hrp_in_if.
`default_nettype none

module hrp_front import hrp_pkg::*; (
    hrp_in_if.sink    i_in,
    input  wire       i_full,
    output logic      o_push,
    output t_q_item   o_item
);

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    always_comb begin
        o_item.first = i_in.first;
        o_item.cls   = classify(i_in.data_byte);
    end

endmodule

`default_nettype wire

@@ src/hrp_queue.sv @@
// Two-entry queue of classified items between the front and back parts.
// Depends on hrp_pkg.
`default_nettype none

module hrp_queue import hrp_pkg::*; (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_push,
    input  wire t_q_item i_item,
    input  wire          i_pop,
    output logic         o_full,
    output logic         o_empty,
    output t_q_item      o_item
);

    t_q_item    r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ src/hrp_back.sv @@
// Back part: the request grammar state machine and the output result register.
// Depends on hrp_pkg and hrp_out_if.
`default_nettype none

module hrp_back import hrp_pkg::*; (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire [BYTE_W-1:0]  i_max_headers,
    input  wire               i_empty,
    input  wire t_q_item      i_item,
    output logic              o_pop,
    hrp_out_if.source         o_res
);

    localparam logic [4:0] PH_MSTART = 5'd0;
    localparam logic [4:0] PH_METHOD = 5'd1;
    localparam logic [4:0] PH_SP1    = 5'd2;
    localparam logic [4:0] PH_URI    = 5'd3;
    localparam logic [4:0] PH_SP2    = 5'd4;
    localparam logic [4:0] PH_T1     = 5'd5;
    localparam logic [4:0] PH_T2     = 5'd6;
    localparam logic [4:0] PH_P      = 5'd7;
    localparam logic [4:0] PH_SLASH  = 5'd8;
    localparam logic [4:0] PH_ONE    = 5'd9;
    localparam logic [4:0] PH_DOT    = 5'd10;
    localparam logic [4:0] PH_DIG0   = 5'd11;
    localparam logic [4:0] PH_DIG    = 5'd12;
    localparam logic [4:0] PH_RLCR   = 5'd13;
    localparam logic [4:0] PH_LINE   = 5'd14;
    localparam logic [4:0] PH_FINCR  = 5'd15;
    localparam logic [4:0] PH_KEY    = 5'd16;
    localparam logic [4:0] PH_KEYSP  = 5'd17;
    localparam logic [4:0] PH_VSKIP  = 5'd18;
    localparam logic [4:0] PH_VAL    = 5'd19;
    localparam logic [4:0] PH_VCR    = 5'd20;
    localparam logic [4:0] PH_DONE   = 5'd21;
    localparam logic [4:0] PH_BAD    = 5'd22;
    localparam logic [4:0] PH_MANY   = 5'd23;

    logic [4:0]          r_phase;
    logic [4:0]          n_phase;
    logic [IDX_W-1:0]    r_hcount;
    logic [IDX_W-1:0]    n_hcount;
    logic                r_valid;
    logic [ROLE_W-1:0]   r_role;
    logic [IDX_W-1:0]    r_idx;
    logic                r_crd;
    logic [STATUS_W-1:0] r_status;

    logic [4:0]          ph;
    logic [IDX_W-1:0]    hc;
    logic [ROLE_W-1:0]   role;
    logic [ROLE_W-1:0]   n_role;
    logic [IDX_W-1:0]    n_idx;
    logic                n_crd;
    logic [STATUS_W-1:0] n_status;
    logic                hdr;
    t_cls                k;

    // Take the next item whenever the result register is free or being drained.
    assign o_pop = !i_empty && (!r_valid || o_res.ready);

    always_comb begin
        k        = i_item.cls;
        ph       = i_item.first ? PH_MSTART : r_phase;
        hc       = i_item.first ? '0 : r_hcount;
        n_phase  = ph;
        n_hcount = hc;
        role     = ROLE_REJECTED;
        n_idx    = '0;
        n_crd    = 1'b0;
        n_status = ST_BUSY;
        hdr      = 1'b0;

        unique case (ph)
            PH_MSTART: begin
                if (k.tok) begin role = ROLE_METHOD; n_phase = PH_METHOD; end
                else n_phase = PH_BAD;
            end
            PH_METHOD: begin
                if (k.tok) role = ROLE_METHOD;
                else if (k.sp) begin role = ROLE_SP1; n_phase = PH_SP1; end
                else n_phase = PH_BAD;
            end
            PH_SP1: begin
                if (k.sp) role = ROLE_SP1;
                else if (k.uri) begin role = ROLE_URI; n_phase = PH_URI; end
                else n_phase = PH_BAD;
            end
            PH_URI: begin
                if (k.uri) role = ROLE_URI;
                else if (k.sp) begin role = ROLE_SP2; n_phase = PH_SP2; end
                else n_phase = PH_BAD;
            end
            PH_SP2: begin
                if (k.sp) role = ROLE_SP2;
                else if (k.ch_h) begin role = ROLE_VERSION; n_phase = PH_T1; end
                else n_phase = PH_BAD;
            end
            PH_T1: begin
                if (k.ch_t) begin role = ROLE_VERSION; n_phase = PH_T2; end
                else n_phase = PH_BAD;
            end
            PH_T2: begin
                if (k.ch_t) begin role = ROLE_VERSION; n_phase = PH_P; end
                else n_phase = PH_BAD;
            end
            PH_P: begin
                if (k.ch_p) begin role = ROLE_VERSION; n_phase = PH_SLASH; end
                else n_phase = PH_BAD;
            end
            PH_SLASH: begin
                if (k.ch_slash) begin role = ROLE_VERSION; n_phase = PH_ONE; end
                else n_phase = PH_BAD;
            end
            PH_ONE: begin
                if (k.ch_one) begin role = ROLE_VERSION; n_phase = PH_DOT; end
                else n_phase = PH_BAD;
            end
            PH_DOT: begin
                if (k.ch_dot) begin role = ROLE_VERSION; n_phase = PH_DIG0; end
                else n_phase = PH_BAD;
            end
            PH_DIG0: begin
                if (k.digit) begin role = ROLE_VERSION; n_phase = PH_DIG; end
                else n_phase = PH_BAD;
            end
            PH_DIG: begin
                if (k.digit) role = ROLE_VERSION;
                else if (k.cr) begin role = ROLE_RL_EOL; n_phase = PH_RLCR; end
                else n_phase = PH_BAD;
            end
            PH_RLCR: begin
                if (k.lf) begin role = ROLE_RL_EOL; n_phase = PH_LINE; end
                else n_phase = PH_BAD;
            end
            PH_LINE: begin
                hdr = 1'b1;
                if (k.cr) begin role = ROLE_FINAL_EOL; n_phase = PH_FINCR; end
                else if (k.tok) begin role = ROLE_KEY; n_phase = PH_KEY; end
                else n_phase = PH_BAD;
            end
            PH_FINCR: begin
                hdr = 1'b1;
                if (k.lf) begin role = ROLE_FINAL_EOL; n_phase = PH_DONE; end
                else n_phase = PH_BAD;
            end
            PH_KEY: begin
                hdr = 1'b1;
                if (k.tok) role = ROLE_KEY;
                else if (k.sp) begin role = ROLE_KEY_SP; n_phase = PH_KEYSP; end
                else if (k.colon) begin role = ROLE_COLON; n_phase = PH_VSKIP; end
                else n_phase = PH_BAD;
            end
            PH_KEYSP: begin
                hdr = 1'b1;
                if (k.sp) role = ROLE_KEY_SP;
                else if (k.colon) begin role = ROLE_COLON; n_phase = PH_VSKIP; end
                else n_phase = PH_BAD;
            end
            PH_VSKIP: begin
                hdr = 1'b1;
                if (k.sp) role = ROLE_VAL_SP;
                else if (k.cr) begin role = ROLE_HDR_EOL; n_phase = PH_VCR; end
                else begin role = ROLE_VALUE; n_phase = PH_VAL; end
            end
            PH_VAL: begin
                hdr = 1'b1;
                if (k.cr) begin role = ROLE_HDR_EOL; n_phase = PH_VCR; end
                else role = ROLE_VALUE;
            end
            PH_VCR: begin
                if (k.lf) begin
                    // The CR was a real line end: this header line is complete.
                    role  = ROLE_HDR_EOL;
                    n_idx = hc;
                    if (hc >= i_max_headers) begin
                        n_phase  = PH_MANY;
                        n_status = ST_MANY;
                    end else begin
                        n_hcount = hc + 1'b1;
                        n_phase  = PH_LINE;
                    end
                end else begin
                    // The CR turned out to be value data.
                    hdr   = 1'b1;
                    n_crd = 1'b1;
                    if (k.cr) role = ROLE_HDR_EOL;
                    else begin role = ROLE_VALUE; n_phase = PH_VAL; end
                end
            end
            PH_DONE: role = ROLE_AFTER_END;
            PH_MANY: role = ROLE_REJECTED;
            default: n_phase = PH_BAD;
        endcase

        if (hdr || n_phase >= PH_DONE) begin
            n_idx = n_hcount;
        end
        if (n_phase == PH_DONE) n_status = ST_DONE;
        else if (n_phase == PH_BAD) n_status = ST_INVALID;
        else if (n_phase == PH_MANY) n_status = ST_MANY;

        n_role = role;
        if (n_phase == PH_BAD || (n_phase == PH_MANY && role == ROLE_REJECTED)) begin
            n_role = ROLE_REJECTED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_MSTART;
            r_hcount <= '0;
            r_valid  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase  <= n_phase;
                r_hcount <= n_hcount;
                r_valid  <= 1'b1;
            end else if (o_res.ready) begin
                r_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_role   <= n_role;
            r_idx    <= n_idx;
            r_crd    <= n_crd;
            r_status <= n_status;
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.role         = r_role;
    assign o_res.header_index = r_idx;
    assign o_res.cr_was_data  = r_crd;
    assign o_res.status       = r_status;

endmodule

`default_nettype wire

@@ src/http1_request_byte_parser.sv @@
// Top level of the HTTP/1 request byte parser: front, queue, back and config register.
// Depends on hrp_pkg, hrp_if, hrp_front, hrp_queue and hrp_back.
//
// Usage: request bytes arrive one per item on i_in (data_byte plus a first flag
// that restarts parsing). For every byte accepted, exactly one result item leaves
// on o_res with the byte's role, its header line index, a flag telling whether
// the preceding CR proved to be value data, and the parse status after it.
// A byte is accepted on a rising edge where i_in.valid and i_in.ready are high;
// a result is taken where o_res.valid and o_res.ready are high.
// Throughput is one byte per cycle while o_res.ready stays high: the grammar advances by one step of a
// small state machine per byte, and that step is the only serial dependency.
// From acceptance, the byte enters the two-entry queue at the accepting edge,
// moves into the output result register once that register is free or being
// drained, and is shown on o_res from then on.
// When the receiver stalls, the held result stays put and the queue absorbs up
// to two more bytes before i_in.ready drops; no item is lost or repeated.
// The synchronous active-low reset empties the queue and the result register,
// returns the parser to the start of a request line and sets max_headers to 64.
// Write max_headers via i_cfg_we / i_cfg_data while the block is idle (not enforced).
`default_nettype none

module http1_request_byte_parser import hrp_pkg::*; (
    input  wire              i_clk,
    input  wire              i_rst_n,
    hrp_in_if.sink           i_in,
    hrp_out_if.source        o_res,
    input  wire              i_cfg_we,
    input  wire [BYTE_W-1:0] i_cfg_data
);

    logic [BYTE_W-1:0] r_max_headers;
    logic              push;
    logic              pop;
    logic              q_full;
    logic              q_empty;
    t_q_item           front_item;
    t_q_item           q_item;

    // The one configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_headers <= MAX_HEADERS_RST;
        end else if (i_cfg_we) begin
            r_max_headers <= i_cfg_data;
        end
    end

    // The front classifies each byte so the back only sees class flags.
    hrp_front u_front (
        .i_in    (i_in),
        .i_full  (q_full),
        .o_push  (push),
        .o_item  (front_item)
    );

    // The queue lets the front keep accepting while a result waits.
    hrp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_item  (q_item)
    );

    // The back runs the grammar and holds the result register.
    hrp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_max_headers (r_max_headers),
        .i_empty       (q_empty),
        .i_item        (q_item),
        .o_pop         (pop),
        .o_res         (o_res)
    );

    // A finished request is only reported on its final line end or after it.
    a_done_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.status == ST_DONE) |->
        (o_res.role == ROLE_FINAL_EOL || o_res.role == ROLE_AFTER_END))
        else $error("done status on a byte that does not end the request");

    // An invalid request always marks the byte as rejected.
    a_invalid_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.status == ST_INVALID) |-> (o_res.role == ROLE_REJECTED))
        else $error("invalid status without rejected role");

    // Only header value bytes can reveal that the previous CR was data.
    a_crd_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.cr_was_data) |->
        (o_res.role == ROLE_VALUE || o_res.role == ROLE_HDR_EOL))
        else $error("cr_was_data on a byte outside a header value");

    // The back part never pops the queue while it is empty:
    // a pop happens only when the queue holds an item.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_empty)
        else $error("queue popped while empty");

endmodule

`default_nettype wire
